>>> rtl/scvs_pkg.sv
// ----------------------------------------------------------------------------
// scvs_pkg
// Shared widths, codes and types for the second chance victim select unit.
// ----------------------------------------------------------------------------
`default_nettype none

package scvs_pkg;

   // Stream payload widths (whole bytes for tdata)
   localparam int REQ_TDATA_W = 8;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 8;
   localparam int RSP_TUSER_W = 1;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   // Buffer count register width; also holds every scan position
   localparam int N_W = 7;
   localparam int ENTRY_W = 6;

   localparam logic [CSR_IDX_W-1:0] REG_BUFFERS_IN_USE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BULK_FLUSH     = 1'd1;

   localparam logic REQ_ACCESS   = 1'b0;
   localparam logic REQ_ALLOCATE = 1'b1;

   localparam logic ST_OK          = 1'b0;
   localparam logic ST_UNSUPPORTED = 1'b1;

   typedef enum logic [5:0] {
      S_CLEAR  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_REDUCE = 6'b000100,
      S_READ   = 6'b001000,
      S_CHECK  = 6'b010000,
      S_RESP   = 6'b100000
   } state_type;

endpackage

`default_nettype wire

>>> rtl/second_chance_victim_select_unit.sv
// ----------------------------------------------------------------------------
// second_chance_victim_select_unit
// Clock (second chance) replacement: referenced and dirty bits per buffer,
// one clock hand per pool, victim selection on allocate requests.
// ----------------------------------------------------------------------------
// Access request: no result; the unit stays idle, so the next request follows at once.
// Allocate request: the hand is reduced modulo the count, then entries are
//   scanned from it, between 1 and count + 1 of them; each entry costs a read
//   and a write-back on the bit memories. Refused allocate (bulk flush): no scan.
// Reset (synchronous, active high) clears control state and starts a clearing
//   pass over all 2**(pool bits + index bits) entries (128 by default) of the bit
//   memories; no request is taken until it ends, CSR writes are taken as ever.
// ----------------------------------------------------------------------------
`default_nettype none

module second_chance_victim_select_unit #(
   parameter int MAX_BUFS  = 64,
   parameter int NUM_POOLS = 2
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [scvs_pkg::REQ_TDATA_W-1:0]   req_tdata,  // entry_index[5:0], mark_dirty[6]
   input  wire logic [scvs_pkg::REQ_TUSER_W-1:0]   req_tuser,  // req_type[0], pool_sel[1]
   // result channel
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [scvs_pkg::RSP_TDATA_W-1:0]        rsp_tdata,  // victim_index[5:0], victim_was_dirty[6]
   output logic [scvs_pkg::RSP_TUSER_W-1:0]        rsp_tuser,  // alloc_status[0]
   // configuration writes
   input  wire logic                               csr_wr_en,
   input  wire logic [scvs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [scvs_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import scvs_pkg::*;

   localparam int IDX_W  = $clog2(MAX_BUFS);
   localparam int POOL_W = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
   localparam int AW     = POOL_W + IDX_W;
   localparam int DEPTH  = 2 ** AW;
   // largest count the 7-bit register can ask for, capped by the pool size
   localparam int CAP    = (MAX_BUFS > 127) ? 127 : MAX_BUFS;
   localparam logic [N_W-1:0] CAP_N = N_W'(CAP);

   // configuration
   logic [N_W-1:0]     biu_ff, biu_in;
   logic               bulk_ff, bulk_in;
   logic [N_W-1:0]     n_use;

   // control
   state_type          state_ff, state_in;
   logic [N_W-1:0]     pos_ff, pos_in;
   logic [N_W-1:0]     pos_next;
   logic [POOL_W-1:0]  pool_ff, pool_in;
   logic [N_W-1:0]     hand_ff [NUM_POOLS];
   logic [N_W-1:0]     hand_in [NUM_POOLS];
   logic [AW-1:0]      clr_addr_ff, clr_addr_in;

   // pending result
   logic [ENTRY_W-1:0] res_idx_ff, res_idx_in;
   logic               res_dirty_ff, res_dirty_in;
   logic               res_status_ff, res_status_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ENTRY_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic               rsp_dirty_ff, rsp_dirty_in;
   logic               rsp_status_ff, rsp_status_in;
   logic               rsp_free;

   // bit memories, one write and one registered read each
   logic               ref_mem   [DEPTH];
   logic               dirty_mem [DEPTH];
   logic               ref_rd_ff, dirty_rd_ff;
   logic               rd_en;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic               ref_we, ref_wd, dirty_we, dirty_wd;

   // request decode
   logic               req_acc;
   logic               req_kind;
   logic [POOL_W-1:0]  req_pool;
   logic [ENTRY_W-1:0] req_entry;
   logic               req_mark;
   logic               req_in_range;

   assign req_kind     = req_tuser[0];
   assign req_pool     = (NUM_POOLS > 1) ? POOL_W'(req_tuser[1]) : '0;
   assign req_entry    = req_tdata[ENTRY_W-1:0];
   assign req_mark     = req_tdata[ENTRY_W];
   assign req_tready   = (state_ff == S_IDLE);
   assign req_acc      = req_tvalid && req_tready;
   assign req_in_range = N_W'(req_entry) < n_use;

   // count in use: zero reads as one, anything above the pool as the pool size
   always_comb begin
      if (biu_ff == '0) begin
         n_use = N_W'(1);
      end else if (biu_ff > CAP_N) begin
         n_use = CAP_N;
      end else begin
         n_use = biu_ff;
      end
   end

   assign pos_next = ((pos_ff + N_W'(1)) == n_use) ? '0 : (pos_ff + N_W'(1));
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // CSR writes
   always_comb begin
      biu_in  = biu_ff;
      bulk_in = bulk_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_BUFFERS_IN_USE: biu_in  = csr_wdata;
            REG_BULK_FLUSH:     bulk_in = csr_wdata[0];
         endcase
      end
   end

   // Sequencer. A scan step is READ (address out) then CHECK (data back,
   // write-back). The write-back is made in CHECK, before the next READ, so it
   // always lands before the next read of the same entry (one-entry pool included).
   // When every bit is set the first pass clears them all and the scan
   // simply comes round to the start entry, now clear, and takes it.
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      pool_in       = pool_ff;
      hand_in       = hand_ff;
      clr_addr_in   = clr_addr_ff;
      res_idx_in    = res_idx_ff;
      res_dirty_in  = res_dirty_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_idx_in    = rsp_idx_ff;
      rsp_dirty_in  = rsp_dirty_ff;
      rsp_status_in = rsp_status_ff;
      rd_en         = 1'b0;
      rd_addr       = {pool_ff, IDX_W'(pos_ff)};
      wr_addr       = {pool_ff, IDX_W'(pos_ff)};
      ref_we        = 1'b0;
      ref_wd        = 1'b0;
      dirty_we      = 1'b0;
      dirty_wd      = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            wr_addr     = clr_addr_ff;
            ref_we      = 1'b1;
            dirty_we    = 1'b1;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               if (req_kind == REQ_ACCESS) begin
                  // out-of-range access is dropped
                  wr_addr  = {req_pool, IDX_W'(req_entry)};
                  ref_we   = req_in_range;
                  ref_wd   = 1'b1;
                  dirty_we = req_in_range && req_mark;
                  dirty_wd = 1'b1;
               end else if (bulk_ff) begin
                  res_idx_in    = '0;
                  res_dirty_in  = 1'b0;
                  res_status_in = ST_UNSUPPORTED;
                  state_in      = S_RESP;
               end else begin
                  pool_in  = req_pool;
                  pos_in   = hand_ff[req_pool];
                  state_in = S_REDUCE;
               end
            end
         end
         S_REDUCE: begin
            // hand modulo count, by repeated subtraction
            if (pos_ff >= n_use) begin
               pos_in = pos_ff - n_use;
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            ref_we = 1'b1;
            ref_wd = 1'b0;
            if (ref_rd_ff) begin
               // second chance: clear and move on
               pos_in   = pos_next;
               state_in = S_READ;
            end else begin
               dirty_we          = 1'b1;
               dirty_wd          = 1'b0;
               res_idx_in        = pos_ff[ENTRY_W-1:0];
               res_dirty_in      = dirty_rd_ff;
               res_status_in     = ST_OK;
               hand_in[pool_ff]  = pos_next;
               state_in          = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_idx_in    = res_idx_ff;
               rsp_dirty_in  = res_dirty_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         biu_ff       <= N_W'(64);
         bulk_ff      <= 1'b0;
         for (int p = 0; p < NUM_POOLS; p++) begin
            hand_ff[p] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         biu_ff       <= biu_in;
         bulk_ff      <= bulk_in;
         hand_ff      <= hand_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      pool_ff       <= pool_in;
      res_idx_ff    <= res_idx_in;
      res_dirty_ff  <= res_dirty_in;
      res_status_ff <= res_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_dirty_ff  <= rsp_dirty_in;
      rsp_status_ff <= rsp_status_in;
   end

   // bit memories
   always_ff @(posedge clock) begin
      if (ref_we) begin
         ref_mem[wr_addr] <= ref_wd;
      end
      if (dirty_we) begin
         dirty_mem[wr_addr] <= dirty_wd;
      end
      if (rd_en) begin
         ref_rd_ff   <= ref_mem[rd_addr];
         dirty_rd_ff <= dirty_mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_dirty_ff, rsp_idx_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

>>> rtl/scvs_checker.sv
// ----------------------------------------------------------------------------
// scvs_checker
// Port-level checks for the second chance victim select unit, with bind.
// ----------------------------------------------------------------------------
`default_nettype none

module scvs_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   input  wire logic                               req_tready,
   input  wire logic [scvs_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  wire logic [scvs_pkg::REQ_TUSER_W-1:0]   req_tuser,
   input  wire logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic [scvs_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  wire logic [scvs_pkg::RSP_TUSER_W-1:0]   rsp_tuser,
   input  wire logic                               csr_wr_en,
   input  wire logic [scvs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [scvs_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import scvs_pkg::*;

   // reset starts the clearing pass: nothing taken, nothing offered
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("request taken or result shown right after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // refused allocation carries no victim
   a_unsup_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] == ST_UNSUPPORTED |-> rsp_tdata == '0)
      else $error("unsupported result with non-zero payload");

   // an access request never creates a result
   a_access_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] == REQ_ACCESS && !rsp_tvalid
      |=> !rsp_tvalid)
      else $error("result appeared after an access request");

endmodule

bind second_chance_victim_select_unit scvs_checker u_scvs_checker (.*);

`default_nettype wire

>>> test/second_chance_victim_select_checker.sv
// ----------------------------------------------------------------------------
// second_chance_victim_select_checker
// Watches the request, result and CSR ports of the victim select unit. It
// keeps its own copy of the referenced and dirty bits and the clock hands,
// works out the victim report for each allocate request and compares every
// result with the oldest report still owed.
// ----------------------------------------------------------------------------
module second_chance_victim_select_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   input  wire logic                             req_tready,
   input  wire logic [scvs_pkg::REQ_TDATA_W-1:0] req_tdata,   // entry_index[5:0], mark_dirty[6]
   input  wire logic [scvs_pkg::REQ_TUSER_W-1:0] req_tuser,   // req_type[0], pool_sel[1]
   input  wire logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   input  wire logic [scvs_pkg::RSP_TDATA_W-1:0] rsp_tdata,   // victim_index[5:0], victim_was_dirty[6]
   input  wire logic [scvs_pkg::RSP_TUSER_W-1:0] rsp_tuser,   // alloc_status[0]
   input  wire logic                             csr_wr_en,
   input  wire logic [scvs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [scvs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                                    report_errors,
   output int                                    reports_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   import scvs_pkg::*;

   localparam int BUFS  = 64;
   localparam int POOLS = 2;

   typedef struct packed {
      logic [ENTRY_W-1:0] victim_index;
      logic               victim_was_dirty;
      logic               alloc_status;
   } victim_report_type;

   logic [BUFS-1:0]  referenced_map [POOLS];
   logic [BUFS-1:0]  dirty_map [POOLS];
   int unsigned      hand_pos [POOLS];
   logic [N_W-1:0]   buffers_reg;
   logic             flush_reg;

   victim_report_type pending_reports [$];
   victim_report_type got, want;
   int               mismatch_total = 0;
   int               owed_now = 0;

   assign report_errors = mismatch_total;
   assign reports_owed  = owed_now;

   // Buffers the hand wraps over, clamped to 1..BUFS
   function automatic int unsigned pool_span();
      int unsigned n;
      n = buffers_reg;
      if (n == 0) n = 1;
      if (n > BUFS) n = BUFS;
      return n;
   endfunction

   function automatic victim_report_type choose_victim(input int unsigned pool);
      victim_report_type rep;
      int unsigned    n, start, cur, victim, i;
      bit             found;
      rep = '0;
      if (flush_reg) begin
         rep.alloc_status = ST_UNSUPPORTED;
         return rep;
      end
      n      = pool_span();
      start  = hand_pos[pool] % n;
      victim = start;
      found  = 1'b0;
      for (i = 0; i < n && !found; i++) begin
         cur = (start + i) % n;
         if (!referenced_map[pool][cur]) begin
            victim = cur;
            found  = 1'b1;
         end else begin
            referenced_map[pool][cur] = 1'b0;
         end
      end
      // nothing clear: the pass emptied every bit, take the hand's entry
      rep.victim_index     = ENTRY_W'(victim);
      rep.victim_was_dirty = dirty_map[pool][victim];
      rep.alloc_status     = ST_OK;
      referenced_map[pool][victim] = 1'b0;
      dirty_map[pool][victim]      = 1'b0;
      hand_pos[pool] = (victim + 1) % n;
      return rep;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < POOLS; p++) begin
            referenced_map[p] = '0;
            dirty_map[p]      = '0;
            hand_pos[p]       = 0;
         end
         buffers_reg = N_W'(BUFS);
         flush_reg   = 1'b0;
         pending_reports.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == REG_BUFFERS_IN_USE) buffers_reg = csr_wdata[N_W-1:0];
            else if (csr_index == REG_BULK_FLUSH) flush_reg = csr_wdata[0];
         end

         // results first, so a stray one is never matched to a fresh request
         if (rsp_tvalid && rsp_tready) begin
            got.victim_index     = rsp_tdata[ENTRY_W-1:0];
            got.victim_was_dirty = rsp_tdata[ENTRY_W];
            got.alloc_status     = rsp_tuser[0];
            if (pending_reports.size() == 0) begin
               $error("result with no allocate request outstanding: %p", got);
               mismatch_total++;
            end else begin
               want = pending_reports.pop_front();
               if (got.victim_index !== want.victim_index) begin
                  $error("victim_index: expected %0d, got %0d",
                         want.victim_index, got.victim_index);
                  mismatch_total++;
               end
               if (got.victim_was_dirty !== want.victim_was_dirty) begin
                  $error("victim_was_dirty: expected %0d, got %0d",
                         want.victim_was_dirty, got.victim_was_dirty);
                  mismatch_total++;
               end
               if (got.alloc_status !== want.alloc_status) begin
                  $error("alloc_status: expected %0d, got %0d",
                         want.alloc_status, got.alloc_status);
                  mismatch_total++;
               end
            end
         end

         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == REQ_ALLOCATE) begin
               pending_reports.push_back(choose_victim(req_tuser[1]));
            end else if (req_tdata[ENTRY_W-1:0] < pool_span()) begin
               referenced_map[req_tuser[1]][req_tdata[ENTRY_W-1:0]] = 1'b1;
               if (req_tdata[ENTRY_W])
                  dirty_map[req_tuser[1]][req_tdata[ENTRY_W-1:0]] = 1'b1;
            end
         end
      end
      owed_now <= pending_reports.size();
   end

endmodule

>>> test/second_chance_victim_select_unit_tb.sv
// ----------------------------------------------------------------------------
// second_chance_victim_select_unit_tb
// Drives access and allocate requests into the victim select unit through a
// run of buffer counts and bulk flush settings, with random stalls on both
// channels. The checker beside the block predicts and compares every result;
// this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module second_chance_victim_select_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import scvs_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;  // quiet cycles
   localparam int SETTLE_CYCLES  = 16;    // after the last result, before CSR writes
   localparam int TAIL_CYCLES    = 250;   // catches any late or stray result
   localparam int BLOCK_ITEMS    = 94;
   localparam int N_BLOCKS       = 12;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   int          report_errors;
   int          reports_owed;
   int          send_idle_pct = 14;
   int          recv_idle_pct = 80;
   int unsigned live_count    = 64;   // clamped buffer count, for shaping stimulus
   int          quiet_cycles  = 0;

   // Buffer count and bulk flush for each random block. Zero and values above
   // the pool size exercise the clamping; flush blocks refuse every allocate.
   int unsigned block_count [N_BLOCKS] = '{64, 2, 0, 9, 127, 5, 40, 1, 63, 4, 100, 64};
   bit          block_flush [N_BLOCKS] = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 0};

   second_chance_victim_select_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   second_chance_victim_select_checker victim_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .report_errors (report_errors),
      .reports_owed  (reports_owed)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Result side back-pressure, redrawn every cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: any handshake on either channel counts as progress
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One request. tvalid is left high after the handshake unless a gap is
   // drawn, so back-to-back requests never lower and raise it in one step.
   task automatic send_request(input logic kind, input logic pool,
                               input logic [ENTRY_W-1:0] entry, input logic dirty);
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, dirty, entry};
      req_tuser  <= {pool, kind};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         // idle with junk on the bus
         req_tvalid <= 1'b0;
         req_tdata  <= REQ_TDATA_W'($urandom);
         req_tuser  <= REQ_TUSER_W'($urandom);
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
   endtask

   // Hold the sender until every owed result has come back. The first edge
   // lets the checker count a request accepted at this very edge.
   task automatic drain_pause();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (reports_owed != 0) @(posedge clock);
   endtask

   // Both registers are written only with the block idle
   task automatic reconfigure(input int unsigned count, input bit flush);
      drain_pause();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= REG_BUFFERS_IN_USE;
      csr_wdata <= CSR_DATA_W'(count);
      @(posedge clock);
      // upper bits of the flush write are don't-care, so toggle them too
      csr_index <= REG_BULK_FLUSH;
      csr_wdata <= {(CSR_DATA_W-1)'($urandom), flush};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      live_count = (count == 0) ? 1 : ((count > 64) ? 64 : count);
   endtask

   task automatic directed_checks();
      // default setting: 64 buffers, allocation allowed
      send_request(REQ_ALLOCATE, 1'b0, 6'd0,  1'b0);  // empty pool: hand's own entry
      send_request(REQ_ACCESS,   1'b0, 6'd0,  1'b1);
      send_request(REQ_ACCESS,   1'b0, 6'd63, 1'b1);  // top entry, dirty
      send_request(REQ_ACCESS,   1'b1, 6'd0,  1'b0);
      send_request(REQ_ACCESS,   1'b1, 6'd1,  1'b1);
      send_request(REQ_ALLOCATE, 1'b0, 6'd63, 1'b1);  // fields ignored on allocate
      send_request(REQ_ALLOCATE, 1'b1, 6'd0,  1'b0);  // second chance for 0 and 1
      send_request(REQ_ALLOCATE, 1'b1, 6'd0,  1'b0);

      // two buffers: both hands now sit beyond the count
      reconfigure(2, 1'b0);
      send_request(REQ_ACCESS,   1'b0, 6'd0,  1'b1);
      send_request(REQ_ACCESS,   1'b0, 6'd1,  1'b0);
      send_request(REQ_ACCESS,   1'b0, 6'd40, 1'b1);  // beyond the count, ignored
      send_request(REQ_ALLOCATE, 1'b0, 6'd0,  1'b0);  // all referenced: scan wraps
      send_request(REQ_ALLOCATE, 1'b1, 6'd0,  1'b0);

      // zero buffers counts as one; bulk flush refuses allocation
      reconfigure(0, 1'b1);
      send_request(REQ_ALLOCATE, 1'b0, 6'd0,  1'b0);
      send_request(REQ_ACCESS,   1'b1, 6'd0,  1'b1);
      reconfigure(0, 1'b0);
      send_request(REQ_ALLOCATE, 1'b1, 6'd0,  1'b0);
      send_request(REQ_ALLOCATE, 1'b0, 6'd63, 1'b1);

      // count above the pool size clamps to the full pool
      reconfigure(127, 1'b0);
      send_request(REQ_ACCESS,   1'b1, 6'd63, 1'b1);
      send_request(REQ_ALLOCATE, 1'b1, 6'd0,  1'b0);
      send_request(REQ_ALLOCATE, 1'b1, 6'd0,  1'b0);
   endtask

   // Mostly in-range accesses and allocates; on small pools, now and then a
   // sweep that references every buffer so the next allocate must wrap.
   task automatic random_block(input int items);
      int          sent;
      int unsigned roll;
      int unsigned e;
      logic        pool;
      sent = 0;
      while (sent < items) begin
         roll = $urandom_range(99);
         pool = 1'($urandom);
         if (roll < 3 && live_count <= 16) begin
            for (e = 0; e < live_count; e++)
               send_request(REQ_ACCESS, pool, ENTRY_W'(e), 1'($urandom));
            send_request(REQ_ALLOCATE, pool, ENTRY_W'($urandom), 1'($urandom));
            sent += live_count + 1;
         end else if (roll < 4) begin
            drain_pause();
         end else if (roll < 34) begin
            send_request(REQ_ALLOCATE, pool, ENTRY_W'($urandom), 1'($urandom));
            sent++;
         end else begin
            // one access in five may land beyond the count and be ignored
            if ($urandom_range(4) == 0) e = $urandom_range(63);
            else e = $urandom_range(live_count - 1);
            send_request(REQ_ACCESS, pool, ENTRY_W'(e), 1'($urandom));
            sent++;
         end
      end
   endtask

   initial begin
      int b;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // requests wait on tready through the clearing pass after reset
      directed_checks();
      for (b = 0; b < N_BLOCKS; b++) begin
         if (b == N_BLOCKS / 3) begin
            send_idle_pct = 80;
            recv_idle_pct = 14;
         end else if (b == 2 * N_BLOCKS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         reconfigure(block_count[b], block_flush[b]);
         random_block(BLOCK_ITEMS);
      end
      drain_pause();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (report_errors == 0 && reports_owed == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/scvs_pkg.sv
rtl/second_chance_victim_select_unit.sv
rtl/scvs_checker.sv
test/second_chance_victim_select_checker.sv
test/second_chance_victim_select_unit_tb.sv
